// ----- rtl/lcc_pkg.sv -----
// Package for the Luhn card number classifier.
// Holds the digit types, the chain geometry and the card kind codes.
// Used by lcc_cell, lcc_judge and luhn_card_number_classifier.
`timescale 1ns / 1ps

package lcc_pkg;

	localparam int IN_WIDTH    = 63;
	localparam int NUM_CELLS   = 19;
	localparam int STEPS       = 3;
	localparam int CONV_CYCLES = IN_WIDTH / STEPS;
	localparam int NUM_GROUPS  = 4;
	localparam int GROUP_SIZE  = 5;
	localparam int CNT_WIDTH   = 5;

	typedef logic [3:0] digit_t;
	typedef digit_t [NUM_CELLS-1:0] digit_row_t;
	typedef logic [STEPS-1:0] step_bits_t;

	typedef enum logic [1:0] {
		KIND_NONE      = 2'd0,
		KIND_PREFIX_3X = 2'd1,
		KIND_PREFIX_5X = 2'd2,
		KIND_LEAD_4    = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                card_kind;
		logic                 luhn_ok;
		logic [CNT_WIDTH-1:0] digit_count;
	} result_t;

endpackage

// ----- rtl/lcc_cell.sv -----
// One decimal digit cell of the binary to BCD shift chain.
// Takes STEPS binary bits a cycle, while en is high, from its lower neighbor and hands its carries up.
// Depends on lcc_pkg.
`timescale 1ns / 1ps

module lcc_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clr,
	input  logic                en,
	input  lcc_pkg::step_bits_t shift_in,
	output lcc_pkg::step_bits_t shift_out,
	output lcc_pkg::digit_t     digit
);

	lcc_pkg::digit_t digit_q;
	lcc_pkg::digit_t digit_next;

	always_comb begin
		lcc_pkg::digit_t v;
		v = digit_q;
		shift_out = '0;
		for (int k = 0; k < lcc_pkg::STEPS; k++) begin
			if (v >= 4'd5) begin
				v = v + 4'd3;
			end
			shift_out[k] = v[3];
			v = {v[2:0], shift_in[k]};
		end
		digit_next = v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (clr) begin
			digit_q <= '0;
		end else if (en) begin
			digit_q <= digit_next;
		end
	end

	assign digit = digit_q;

endmodule

// ----- rtl/lcc_judge.sv -----
// Luhn sum, digit count, leading digits and kind decision for a finished digit row.
// One registered stage of group sums and prefix digits, then the final decision.
// Depends on lcc_pkg.
`timescale 1ns / 1ps

module lcc_judge #(
	parameter int MAX_DIGITS = 19
) (
	input  logic                clk,
	input  logic                load,
	input  lcc_pkg::digit_row_t digits,
	output lcc_pkg::result_t    result
);

	logic [5:0] grp_s1 [lcc_pkg::NUM_GROUPS];
	logic [lcc_pkg::CNT_WIDTH-1:0] cnt_s1;
	lcc_pkg::digit_t hi_s1;
	lcc_pkg::digit_t lo_s1;

	logic [5:0] grp_d [lcc_pkg::NUM_GROUPS];
	logic [lcc_pkg::CNT_WIDTH-1:0] cnt_d;
	lcc_pkg::digit_t hi_d;
	lcc_pkg::digit_t lo_d;

	always_comb begin
		lcc_pkg::digit_t c;
		int idx;
		for (int g = 0; g < lcc_pkg::NUM_GROUPS; g++) begin
			grp_d[g] = '0;
			for (int j = 0; j < lcc_pkg::GROUP_SIZE; j++) begin
				idx = g * lcc_pkg::GROUP_SIZE + j;
				if (idx < lcc_pkg::NUM_CELLS) begin
					c = digits[idx];
					if ((idx % 2) == 1) begin
						c = (c < 4'd5) ? 4'(c << 1) : 4'((c << 1) - 4'd9);
					end
					grp_d[g] = grp_d[g] + 6'(c);
				end
			end
		end
	end

	always_comb begin
		cnt_d = '0;
		hi_d  = '0;
		lo_d  = '0;
		for (int i = 0; i < lcc_pkg::NUM_CELLS; i++) begin
			if (digits[i] != '0) begin
				cnt_d = lcc_pkg::CNT_WIDTH'(i + 1);
				hi_d  = digits[i];
				lo_d  = (i > 0) ? digits[(i > 0) ? i - 1 : 0] : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_s1 <= grp_d;
			cnt_s1 <= cnt_d;
			hi_s1  <= hi_d;
			lo_s1  <= lo_d;
		end
	end

	logic [7:0]  sum;
	logic [15:0] prod;
	logic [4:0]  quot;
	logic        mod_ok;
	logic        over;
	logic        ok;

	always_comb begin
		sum = 8'(grp_s1[0]) + 8'(grp_s1[1]) + 8'(grp_s1[2]) + 8'(grp_s1[3]);
		prod = 16'(sum) * 16'd205;
		quot = prod[15:11];
		mod_ok = (sum == 8'(quot * 8'd10));
		over = (cnt_s1 > lcc_pkg::CNT_WIDTH'(MAX_DIGITS));
		ok = mod_ok && !over;

		result.luhn_ok = ok;
		result.digit_count = over ? lcc_pkg::CNT_WIDTH'(MAX_DIGITS) : cnt_s1;
		result.card_kind = lcc_pkg::KIND_NONE;
		if (ok) begin
			if (cnt_s1 == 5'd15 && hi_s1 == 4'd3 && (lo_s1 == 4'd4 || lo_s1 == 4'd7)) begin
				result.card_kind = lcc_pkg::KIND_PREFIX_3X;
			end else if (cnt_s1 == 5'd16 && hi_s1 == 4'd5 && lo_s1 >= 4'd1
					&& lo_s1 <= 4'd5) begin
				result.card_kind = lcc_pkg::KIND_PREFIX_5X;
			end else if ((cnt_s1 == 5'd13 || cnt_s1 == 5'd16) && hi_s1 == 4'd4) begin
				result.card_kind = lcc_pkg::KIND_LEAD_4;
			end
		end
	end

endmodule

// ----- rtl/luhn_card_number_classifier.sv -----
// Top level of the Luhn card number classifier.
// Feeds the card number MSB first into a chain of lcc_cell digit cells, then lcc_judge.
// Depends on lcc_pkg, lcc_cell and lcc_judge.
//
// Channel  Dir  Beat contents
// s_axis   in   tdata[62:0] pan
// m_axis   out  tdata[1:0] card_kind, [2] luhn_ok, [7:3] digit_count
//
// An item passes from its input beat to its result beat through the BCD cell chain at
// three bits a cycle, then one judge register stage, then the output register, which
// offers the result beat.
// Reset clears the control state and the output valid; no clearing pass is needed.
// A new card is taken once the previous one has reached the output register, and a
// stalled result holds the block only at its final step.
`timescale 1ns / 1ps

module luhn_card_number_classifier #(
	parameter int MAX_DIGITS = 19
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // [62:0] pan, [63] zero fill
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata   // [1:0] card_kind, [2] luhn_ok, [7:3] digit_count
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CONV  = 4'b0010,
		ST_JUDGE = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q;
	logic [lcc_pkg::IN_WIDTH-1:0] bits_q;
	logic [4:0] step_q;
	logic m_valid_q;
	lcc_pkg::result_t out_q;

	logic in_beat;
	logic out_load;
	logic conv_en;
	lcc_pkg::step_bits_t chain [lcc_pkg::NUM_CELLS+1];
	lcc_pkg::digit_row_t digits;
	lcc_pkg::result_t result;

	assign in_beat = s_axis_tvalid && s_axis_tready;
	assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);
	assign conv_en = (state_q == ST_CONV);

	always_comb begin
		for (int k = 0; k < lcc_pkg::STEPS; k++) begin
			chain[0][k] = bits_q[lcc_pkg::IN_WIDTH-1-k];
		end
	end

	for (genvar i = 0; i < lcc_pkg::NUM_CELLS; i++) begin : g_cell
		lcc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.clr       (in_beat),
			.en        (conv_en),
			.shift_in  (chain[i]),
			.shift_out (chain[i+1]),
			.digit     (digits[i])
		);
	end

	lcc_judge #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_judge (
		.clk    (clk),
		.load   (state_q == ST_JUDGE),
		.digits (digits),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						state_q <= ST_CONV;
						step_q <= '0;
					end
				end
				ST_CONV: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'(lcc_pkg::CONV_CYCLES - 1)) begin
						state_q <= ST_JUDGE;
					end
				end
				ST_JUDGE: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			bits_q <= s_axis_tdata[lcc_pkg::IN_WIDTH-1:0];
		end else if (conv_en) begin
			bits_q <= {bits_q[lcc_pkg::IN_WIDTH-1-lcc_pkg::STEPS:0], lcc_pkg::STEPS'(0)};
		end
		if (out_load) begin
			out_q <= result;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = {out_q.digit_count, out_q.luhn_ok, out_q.card_kind};

endmodule
